### rtl/pfsa_pkg.sv
`timescale 1ns / 1ps

package pfsa_pkg;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_RESERVE = 2'd1,
        CMD_UPGRADE = 2'd2,
        CMD_FREE    = 2'd3
    } t_cmd;

    localparam logic [2:0] ERR_OK              = 3'd0;
    localparam logic [2:0] ERR_NO_RESERVATION  = 3'd1;
    localparam logic [2:0] ERR_ZERO_UNRESERVED = 3'd2;
    localparam logic [2:0] ERR_MISALIGNED      = 3'd3;
    localparam logic [2:0] ERR_OVERFLOW        = 3'd4;

    localparam int unsigned ADDR_BITS = 32;
    localparam int unsigned ZPN_BITS  = 20;

endpackage

### rtl/pfsa_frame_ram.sv
`timescale 1ns / 1ps

module pfsa_frame_ram
    import pfsa_pkg::*;
#(
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned WIDTH = 20
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/page_frame_stack_allocator_top.sv
`timescale 1ns / 1ps
// Channel  | Direction | Handshake                  | Payload
// request  | in        | i_req_valid / o_req_ready  | i_command, i_frame_address
// result   | out       | o_res_valid / i_res_ready  | o_result_address, o_is_zero_page,
//          |           |                            | o_error_code
// config   | in        | i_cfg_valid / o_cfg_ready  | i_cfg_zero_page_number
//
// One request at a time through a single-port frame RAM (one access a cycle).
// Accept to result register: reserve and free pass S_EXEC, S_DONE; allocate adds
// S_RTOP; upgrade S_RTOP, S_RSWAP, S_WSWAP (two reads, two writes); then S_IDLE.
// S_DONE holds while the output register is full and not being taken.
// Reset (synchronous, active low) empties the stack and clears the zero page number.
// Config is taken only when idle with no request pending; nothing is taken in reset.

module page_frame_stack_allocator_top
    import pfsa_pkg::*;
#(
    parameter int unsigned STACK_DEPTH      = 4096,
    parameter int unsigned PAGE_OFFSET_BITS = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    output logic                 o_req_ready,
    input  logic [1:0]           i_command,
    input  logic [ADDR_BITS-1:0] i_frame_address,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output logic [ADDR_BITS-1:0] o_result_address,
    output logic                 o_is_zero_page,
    output logic [2:0]           o_error_code,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [ZPN_BITS-1:0]  i_cfg_zero_page_number
);

    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned PB = ADDR_BITS - PAGE_OFFSET_BITS;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_RTOP  = 6'b000100,
        S_RSWAP = 6'b001000,
        S_WSWAP = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    t_cmd                  r_cmd;
    logic [ADDR_BITS-1:0]  r_addr;
    logic [ZPN_BITS-1:0]   r_zpn;
    logic [CW-1:0]         r_free_count, n_free_count;
    logic [CW-1:0]         r_resv_count, n_resv_count;
    logic [AW-1:0]         r_ra, n_ra;
    logic [AW-1:0]         r_fa, n_fa;
    logic [PB-1:0]         r_taken, n_taken;
    logic [ADDR_BITS-1:0]  r_result, n_result;
    logic [2:0]            r_err, n_err;
    logic                  r_out_valid;
    logic [ADDR_BITS-1:0]  r_out_addr;
    logic                  r_out_isz;
    logic [2:0]            r_out_err;

    logic                  ram_en;
    logic                  ram_we;
    logic [AW-1:0]         ram_addr;
    logic [PB-1:0]         ram_wdata;
    logic [PB-1:0]         ram_rdata;

    logic [ADDR_BITS+ZPN_BITS-1:0] zaddr_wide;
    logic [ADDR_BITS-1:0]  zaddr;
    logic                  is_zero;
    logic                  has_room;
    logic [CW-1:0]         free_m1;
    logic [CW-1:0]         resv_m1;
    logic                  out_free;

    assign zaddr_wide = {{ADDR_BITS{1'b0}}, r_zpn} << PAGE_OFFSET_BITS;
    assign zaddr      = zaddr_wide[ADDR_BITS-1:0];
    assign is_zero    = (r_addr == zaddr);
    assign has_room   = (r_free_count > r_resv_count);
    assign free_m1    = r_free_count - CW'(1);
    assign resv_m1    = r_resv_count - CW'(1);
    assign out_free   = !r_out_valid || i_res_ready;

    assign o_req_ready = i_rst_n && (r_state == S_IDLE);
    assign o_cfg_ready = i_rst_n && (r_state == S_IDLE) && !i_req_valid;

    pfsa_frame_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (PB)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_free_count = r_free_count;
        n_resv_count = r_resv_count;
        n_ra         = r_ra;
        n_fa         = r_fa;
        n_taken      = r_taken;
        n_result     = r_result;
        n_err        = r_err;
        ram_en       = 1'b0;
        ram_we       = 1'b0;
        ram_addr     = r_ra;
        ram_wdata    = r_taken;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_result = '0;
                n_err    = ERR_OK;
                n_state  = S_DONE;
                unique case (r_cmd)
                    CMD_ALLOC: begin
                        if (has_room) begin
                            n_free_count = free_m1;
                            ram_en       = 1'b1;
                            ram_addr     = free_m1[AW-1:0];
                            n_state      = S_RTOP;
                        end
                    end
                    CMD_RESERVE: begin
                        if (has_room) begin
                            n_resv_count = r_resv_count + CW'(1);
                            n_result     = zaddr;
                        end
                    end
                    CMD_UPGRADE: begin
                        if (r_resv_count == '0) begin
                            n_err = ERR_NO_RESERVATION;
                        end else begin
                            n_resv_count = resv_m1;
                            n_free_count = free_m1;
                            n_ra         = resv_m1[AW-1:0];
                            n_fa         = free_m1[AW-1:0];
                            ram_en       = 1'b1;
                            ram_addr     = resv_m1[AW-1:0];
                            n_state      = S_RTOP;
                        end
                    end
                    CMD_FREE: begin
                        if (r_addr[PAGE_OFFSET_BITS-1:0] != '0) begin
                            n_err = ERR_MISALIGNED;
                        end else if (is_zero) begin
                            if (r_resv_count == '0) begin
                                n_err = ERR_ZERO_UNRESERVED;
                            end else begin
                                n_resv_count = resv_m1;
                            end
                        end else if (r_free_count >= CW'(STACK_DEPTH)) begin
                            n_err = ERR_OVERFLOW;
                        end else begin
                            ram_en       = 1'b1;
                            ram_we       = 1'b1;
                            ram_addr     = r_free_count[AW-1:0];
                            ram_wdata    = r_addr[ADDR_BITS-1:PAGE_OFFSET_BITS];
                            n_free_count = r_free_count + CW'(1);
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_RTOP: begin
                n_result = {ram_rdata, {PAGE_OFFSET_BITS{1'b0}}};
                if (r_cmd == CMD_UPGRADE) begin
                    n_taken  = ram_rdata;
                    ram_en   = 1'b1;
                    ram_addr = r_fa;
                    n_state  = S_RSWAP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RSWAP: begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = r_ra;
                ram_wdata = ram_rdata;
                n_state   = S_WSWAP;
            end
            S_WSWAP: begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = r_fa;
                ram_wdata = r_taken;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_free_count <= '0;
            r_resv_count <= '0;
            r_zpn        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_free_count <= n_free_count;
            r_resv_count <= n_resv_count;
            if (i_cfg_valid && o_cfg_ready) begin
                r_zpn <= i_cfg_zero_page_number;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req_valid) begin
            r_cmd  <= t_cmd'(i_command);
            r_addr <= i_frame_address;
        end
        r_ra     <= n_ra;
        r_fa     <= n_fa;
        r_taken  <= n_taken;
        r_result <= n_result;
        r_err    <= n_err;
        if (r_state == S_DONE && out_free) begin
            r_out_addr <= r_result;
            r_out_isz  <= is_zero;
            r_out_err  <= r_err;
        end
    end

    assign o_res_valid      = r_out_valid;
    assign o_result_address = r_out_addr;
    assign o_is_zero_page   = r_out_isz;
    assign o_error_code     = r_out_err;

endmodule

### sim/tb_page_frame_stack_allocator_top.sv
`timescale 1ns / 1ps

module tb_page_frame_stack_allocator_top;
    import pfsa_pkg::*;

    localparam int unsigned STACK_DEPTH        = 4096;
    localparam int unsigned PAGE_OFFSET_BITS   = 12;
    localparam int unsigned DRAIN_CYCLES       = 8;
    localparam int unsigned CYCLE_LIMIT        = 200_000;
    localparam int unsigned RANDOM_PHASE_ITEMS = 190;
    localparam int unsigned FILL_FRAMES        = 120;

    typedef struct packed {
        logic [ADDR_BITS-1:0] address;
        logic                 zero_page;
        logic [2:0]           error_code;
    } t_frame_reply;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_req_valid = 1'b0;
    logic                 o_req_ready;
    logic [1:0]           i_command = CMD_ALLOC;
    logic [ADDR_BITS-1:0] i_frame_address = '0;
    logic                 o_res_valid;
    logic                 i_res_ready = 1'b0;
    logic [ADDR_BITS-1:0] o_result_address;
    logic                 o_is_zero_page;
    logic [2:0]           o_error_code;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [ZPN_BITS-1:0]  i_cfg_zero_page_number = '0;

    // allocator state as seen by the predictor
    logic [ADDR_BITS-1:0] frame_pages [STACK_DEPTH];
    int unsigned          free_frames = 0;
    int unsigned          reserved_frames = 0;
    logic [ZPN_BITS-1:0]  zero_pn = '0;

    t_frame_reply         replies_due [$];
    int unsigned          failures = 0;
    int unsigned          cycle_count = 0;
    int unsigned          send_idle_pct = 0;
    int unsigned          stall_pct = 0;
    int unsigned          ready_hold_cycles = 0;
    int unsigned          cmd_tally [4] = '{default: 0};
    int unsigned          err_tally [5] = '{default: 0};
    int unsigned          zpn_writes = 0;

    page_frame_stack_allocator_top #(
        .STACK_DEPTH      (STACK_DEPTH),
        .PAGE_OFFSET_BITS (PAGE_OFFSET_BITS)
    ) uut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_req_valid            (i_req_valid),
        .o_req_ready            (o_req_ready),
        .i_command              (i_command),
        .i_frame_address        (i_frame_address),
        .o_res_valid            (o_res_valid),
        .i_res_ready            (i_res_ready),
        .o_result_address       (o_result_address),
        .o_is_zero_page         (o_is_zero_page),
        .o_error_code           (o_error_code),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_zero_page_number (i_cfg_zero_page_number)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result sink: random stalls plus an occasional long hold-off
    always @(negedge i_clk) begin
        if (ready_hold_cycles > 0) begin
            ready_hold_cycles--;
            i_res_ready <= 1'b0;
        end else begin
            i_res_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_frame_reply want;
        if (i_rst_n && o_res_valid === 1'b1 && i_res_ready) begin
            if (replies_due.size() == 0) begin
                $error("result with no request outstanding: result_address %h",
                       o_result_address);
                failures++;
            end else begin
                want = replies_due.pop_front();
                if (o_result_address !== want.address) begin
                    $error("result_address: expected %h, got %h", want.address, o_result_address);
                    failures++;
                end
                if (o_is_zero_page !== want.zero_page) begin
                    $error("is_zero_page: expected %b, got %b", want.zero_page, o_is_zero_page);
                    failures++;
                end
                if (o_error_code !== want.error_code) begin
                    $error("error_code: expected %0d, got %0d", want.error_code, o_error_code);
                    failures++;
                end
            end
        end
    end

    function automatic logic [ADDR_BITS-1:0] zero_page_address();
        logic [ADDR_BITS-1:0] ext;
        ext = ADDR_BITS'(zero_pn);
        return ext << PAGE_OFFSET_BITS;
    endfunction

    function automatic void apply_frame_command(t_cmd cmd, logic [ADDR_BITS-1:0] addr);
        logic [ADDR_BITS-1:0] zaddr;
        logic [ADDR_BITS-1:0] offset_mask;
        logic [ADDR_BITS-1:0] taken;
        logic                 has_room;
        t_frame_reply         r;
        zaddr       = zero_page_address();
        offset_mask = (ADDR_BITS'(1) << PAGE_OFFSET_BITS) - 1;
        has_room    = (free_frames > reserved_frames) && (free_frames <= STACK_DEPTH);
        r.address    = '0;
        r.zero_page  = (addr == zaddr);
        r.error_code = ERR_OK;
        case (cmd)
            CMD_ALLOC: begin
                if (has_room) begin
                    free_frames--;
                    r.address = frame_pages[free_frames] << PAGE_OFFSET_BITS;
                end
            end
            CMD_RESERVE: begin
                if (has_room) begin
                    reserved_frames++;
                    r.address = zaddr;
                end
            end
            CMD_UPGRADE: begin
                if (reserved_frames == 0 || free_frames == 0 ||
                    reserved_frames > free_frames || free_frames > STACK_DEPTH) begin
                    r.error_code = ERR_NO_RESERVATION;
                end else begin
                    // swap last reserved slot with the top, then pop it
                    reserved_frames--;
                    taken = frame_pages[reserved_frames];
                    free_frames--;
                    frame_pages[reserved_frames] = frame_pages[free_frames];
                    frame_pages[free_frames] = taken;
                    r.address = taken << PAGE_OFFSET_BITS;
                end
            end
            CMD_FREE: begin
                if ((addr & offset_mask) != 0) begin
                    r.error_code = ERR_MISALIGNED;
                end else if (addr == zaddr) begin
                    if (reserved_frames == 0)
                        r.error_code = ERR_ZERO_UNRESERVED;
                    else
                        reserved_frames--;
                end else if (free_frames >= STACK_DEPTH) begin
                    r.error_code = ERR_OVERFLOW;
                end else begin
                    frame_pages[free_frames] = addr >> PAGE_OFFSET_BITS;
                    free_frames++;
                end
            end
        endcase
        cmd_tally[cmd]++;
        err_tally[r.error_code]++;
        replies_due.push_back(r);
    endfunction

    function automatic logic [ADDR_BITS-1:0] random_frame();
        logic [ADDR_BITS-1:0] a;
        a = $urandom();
        a = (a >> PAGE_OFFSET_BITS) << PAGE_OFFSET_BITS;
        if (a == zero_page_address())
            a[PAGE_OFFSET_BITS] = ~a[PAGE_OFFSET_BITS];
        return a;
    endfunction

    task automatic send_request(input t_cmd cmd, input logic [ADDR_BITS-1:0] addr);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_req_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_req_valid     <= 1'b1;
        i_command       <= cmd;
        i_frame_address <= addr;
        @(posedge i_clk);
        while (!o_req_ready)
            @(posedge i_clk);
        apply_frame_command(cmd, addr);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_req_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_zero_page(input logic [ZPN_BITS-1:0] pn);
        wait_idle();
        @(negedge i_clk);
        i_cfg_valid            <= 1'b1;
        i_cfg_zero_page_number <= pn;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        zero_pn = pn;
        zpn_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_random_request();
        int unsigned          pick;
        logic [ADDR_BITS-1:0] a;
        pick = $urandom_range(99);
        a    = $urandom();
        if ($urandom_range(99) < 15)
            a = zero_page_address();
        if (pick < 38)
            send_request(CMD_FREE, random_frame());
        else if (pick < 62)
            send_request(CMD_ALLOC, a);
        else if (pick < 76)
            send_request(CMD_RESERVE, a);
        else if (pick < 90)
            send_request(CMD_UPGRADE, a);
        else if (pick < 95)
            send_request(CMD_FREE, zero_page_address());
        else
            send_request(CMD_FREE, $urandom());
    endtask

    task automatic test_empty_stack();
        send_request(CMD_ALLOC, '0);
        send_request(CMD_RESERVE, 32'h0000_1000);
        send_request(CMD_UPGRADE, 32'hFFFF_FFFF);
        send_request(CMD_FREE, '0);
        send_request(CMD_FREE, 32'h0000_0FFF);
        send_request(CMD_FREE, 32'hFFFF_FFFF);
        send_request(CMD_FREE, 32'h0000_0800);
    endtask

    task automatic test_basic_ops();
        send_request(CMD_FREE, 32'hFFFF_F000);
        send_request(CMD_FREE, 32'h0000_1000);
        send_request(CMD_FREE, 32'h5A5A_5000);
        send_request(CMD_ALLOC, 32'h0000_0000);
        send_request(CMD_RESERVE, 32'h0000_0000);
        send_request(CMD_RESERVE, 32'hFFFF_F000);
        send_request(CMD_RESERVE, 32'h0000_0000);
        send_request(CMD_ALLOC, 32'hA5A5_A5A5);
        send_request(CMD_UPGRADE, 32'h0000_0000);
        send_request(CMD_UPGRADE, 32'h0000_1000);
        send_request(CMD_UPGRADE, 32'h0000_0000);
        send_request(CMD_FREE, 32'h0000_0000);
        send_request(CMD_FREE, 32'h0000_2000);
        send_request(CMD_RESERVE, 32'h0000_0000);
        send_request(CMD_FREE, 32'h0000_0000);
        send_request(CMD_ALLOC, 32'h0000_0000);
        send_request(CMD_ALLOC, 32'h0000_0000);
    endtask

    task automatic test_zero_page_config();
        write_zero_page(20'hFFFFF);
        send_request(CMD_RESERVE, 32'hFFFF_F000);
        send_request(CMD_FREE, 32'hFFFF_F000);
        send_request(CMD_FREE, 32'h0000_0000);
        send_request(CMD_RESERVE, 32'h0000_0000);
        send_request(CMD_FREE, 32'hFFFF_F000);
        send_request(CMD_ALLOC, 32'hFFFF_F000);
        write_zero_page(20'h00000);
    endtask

    task automatic test_fill_and_drain();
        wait_idle();
        send_idle_pct = 0;
        stall_pct     = 0;
        while (free_frames < FILL_FRAMES)
            send_request(CMD_FREE, random_frame());
        send_request(CMD_FREE, random_frame());
        send_request(CMD_FREE, random_frame());
        send_request(CMD_FREE, zero_page_address());
        repeat (3) send_request(CMD_RESERVE, $urandom());
        send_request(CMD_UPGRADE, $urandom());
        send_request(CMD_FREE, random_frame());
        send_request(CMD_FREE, random_frame());
        send_request(CMD_FREE, zero_page_address());
        while (free_frames > reserved_frames)
            send_request(CMD_ALLOC, $urandom());
        send_request(CMD_ALLOC, $urandom());
        send_request(CMD_RESERVE, $urandom());
        while (reserved_frames > 0)
            send_request(CMD_UPGRADE, $urandom());
        send_request(CMD_UPGRADE, $urandom());
    endtask

    task automatic test_random_traffic(input int unsigned idle, input int unsigned stall,
                                       input logic [ZPN_BITS-1:0] pn);
        write_zero_page(pn);
        send_idle_pct = idle;
        stall_pct     = stall;
        repeat (RANDOM_PHASE_ITEMS) send_random_request();
    endtask

    task automatic test_flow_control();
        wait_idle();
        send_idle_pct     = 0;
        stall_pct         = 0;
        ready_hold_cycles = 300;
        repeat (12) send_random_request();
        // sender holds back until every result is in
        wait_idle();
        stall_pct = 56;
        repeat (10) send_random_request();
        wait_idle();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_stack();
        test_basic_ops();
        test_zero_page_config();
        test_fill_and_drain();
        test_random_traffic(0, 0, ZPN_BITS'($urandom()));
        test_random_traffic(56, 0, 20'hFFFFF);
        test_random_traffic(0, 56, 20'h00001);
        test_random_traffic(32, 32, 20'h80000);
        test_flow_control();
        test_random_traffic(0, 0, 20'h00000);
        wait_idle();

        $display("Covered %0d requests: alloc %0d, reserve %0d, upgrade %0d, free %0d",
                 cmd_tally[0] + cmd_tally[1] + cmd_tally[2] + cmd_tally[3],
                 cmd_tally[CMD_ALLOC], cmd_tally[CMD_RESERVE], cmd_tally[CMD_UPGRADE],
                 cmd_tally[CMD_FREE]);
        $display("%0d zero page writes; ok %0d, no reservation %0d, zero page unreserved %0d,",
                 zpn_writes, err_tally[ERR_OK], err_tally[ERR_NO_RESERVATION],
                 err_tally[ERR_ZERO_UNRESERVED]);
        $display("misaligned %0d, overflow %0d",
                 err_tally[ERR_MISALIGNED], err_tally[ERR_OVERFLOW]);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### sim.f
rtl/pfsa_pkg.sv
rtl/pfsa_frame_ram.sv
rtl/page_frame_stack_allocator_top.sv
sim/tb_page_frame_stack_allocator_top.sv
